@@ hdl/rrpa_pkg.sv @@
// Shared types and constants for the reserved range page allocator.
package rrpa_pkg;

   localparam int ADDR_W     = 64;
   localparam int REQ_W      = 33;
   localparam int SIZE_W     = 34;
   localparam int PAGE_SHIFT = 12;
   localparam logic [SIZE_W-1:0] PAGE_BYTES = SIZE_W'(4096);
   localparam logic [SIZE_W-1:0] PAGE_MASK  = SIZE_W'(4095);

   localparam logic [1:0] MODE_REGION  = 2'd0;
   localparam logic [1:0] MODE_RESERVE = 2'd1;
   localparam logic [1:0] MODE_ALLOC   = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_MEM = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_LOAD_REGION,
      OP_RESERVE,
      OP_ALLOC_INIT,
      OP_SET_RESULT,
      OP_EMIT,
      OP_RG_INC,
      OP_RG_MAX,
      OP_RG_OFF,
      OP_RG_LEFT,
      OP_RG_AVAIL,
      OP_RV_FIRST,
      OP_RV_INC,
      OP_RV_LATCH,
      OP_COMMIT,
      OP_DIV_A,
      OP_TAKE_A,
      OP_DIV_B,
      OP_TAKE_B,
      OP_STEP_ADD,
      OP_STEP_MIN,
      OP_ADVANCE
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RG_READ,
      ST_RG_MAX,
      ST_RG_OFF,
      ST_RG_LEFT,
      ST_RG_AVAIL,
      ST_RG_FIT,
      ST_RV_CHECK,
      ST_RV_TEST,
      ST_DIV_A,
      ST_WAIT_A,
      ST_DIV_B,
      ST_WAIT_B,
      ST_STEP_ADD,
      ST_STEP_MIN,
      ST_STEP_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       usable;
      logic       rg_last;
      logic       fit;
      logic       rv_end;
      logic       overlap;
      logic       rem_done;
      logic       step_fail;
      logic       out_busy;
   } stat_type;

endpackage

@@ hdl/reserved_range_page_allocator.sv @@
// Top level of the reserved range page allocator.
//
//  channel | direction | handshake              | content
//  req     | in        | req_tvalid/req_tready  | tuser mode, tdata item fields
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata alloc_address, status
//  csr     | in        | csr_valid/csr_ready    | csr_data alloc_floor
//
// One item at a time. Region load, reserve and unused mode go through capture,
// dispatch and done. An allocation attempt scans region slots and tests
// reservation entries; each skip past an overlap takes two passes of the
// bit-serial remainder unit.
// A finished result sits in the output register while the next item is taken.
// Reset is synchronous; both tables start empty and the floor is zero.
module reserved_range_page_allocator #(
   parameter int REGION_SLOTS  = 16,
   parameter int RESERVE_SLOTS = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode [1:0]
   input  logic [1:0]   req_tuser,
   // region_index, region_base, region_length, region_usable,
   // reserve_first, reserve_last, request_size
   input  logic [295:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // alloc_address, status
   output logic [71:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_data
);
   import rrpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   rrpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rrpa_datapath #(
      .REGION_SLOTS  (REGION_SLOTS),
      .RESERVE_SLOTS (RESERVE_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hdl/rrpa_ram.sv @@
// Generic single write port RAM with registered read.
module rrpa_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rrpa_rem.sv @@
// Bit-serial remainder unit: one dividend bit per cycle.
module rrpa_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rrpa_pkg::ADDR_W-1:0] dividend,
   input  logic [rrpa_pkg::SIZE_W-1:0] divisor,
   output logic                       done,
   output logic [rrpa_pkg::SIZE_W-1:0] remainder
);
   import rrpa_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   shift_ff, shift_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [SIZE_W:0]     trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[ADDR_W-1]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[ADDR_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = SIZE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = SIZE_W'(trial);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/rrpa_ctrl.sv @@
// Controller state machine sequencing loads, reservations and the allocation search.
module rrpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rrpa_pkg::stat_type stat,
   output rrpa_pkg::cmd_type  cmd
);
   import rrpa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_IDLE;
      cmd.code   = STATUS_OK;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            case (stat.mode)
               MODE_REGION: cmd.op = OP_LOAD_REGION;
               MODE_RESERVE: begin
                  if (stat.full) begin
                     cmd.op   = OP_SET_RESULT;
                     cmd.code = STATUS_FULL;
                  end else begin
                     cmd.op = OP_RESERVE;
                  end
               end
               MODE_ALLOC: begin
                  if (stat.full) begin
                     cmd.op   = OP_SET_RESULT;
                     cmd.code = STATUS_FULL;
                  end else begin
                     cmd.op   = OP_ALLOC_INIT;
                     state_in = ST_RG_READ;
                  end
               end
               default: cmd.op = OP_SET_RESULT;
            endcase
         end
         ST_RG_READ: state_in = ST_RG_MAX;
         ST_RG_MAX: begin
            if (stat.usable) begin
               cmd.op   = OP_RG_MAX;
               state_in = ST_RG_OFF;
            end else if (stat.rg_last) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = STATUS_NO_MEM;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_RG_INC;
               state_in = ST_RG_READ;
            end
         end
         ST_RG_OFF: begin
            cmd.op   = OP_RG_OFF;
            state_in = ST_RG_LEFT;
         end
         ST_RG_LEFT: begin
            cmd.op   = OP_RG_LEFT;
            state_in = ST_RG_AVAIL;
         end
         ST_RG_AVAIL: begin
            cmd.op   = OP_RG_AVAIL;
            state_in = ST_RG_FIT;
         end
         ST_RG_FIT: begin
            if (stat.fit) begin
               cmd.op   = OP_RV_FIRST;
               state_in = ST_RV_CHECK;
            end else if (stat.rg_last) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = STATUS_NO_MEM;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_RG_INC;
               state_in = ST_RG_READ;
            end
         end
         ST_RV_CHECK: begin
            if (stat.rv_end) begin
               cmd.op   = OP_COMMIT;
               state_in = ST_DONE;
            end else begin
               state_in = ST_RV_TEST;
            end
         end
         ST_RV_TEST: begin
            if (stat.overlap) begin
               cmd.op   = OP_RV_LATCH;
               state_in = ST_DIV_A;
            end else begin
               cmd.op   = OP_RV_INC;
               state_in = ST_RV_CHECK;
            end
         end
         ST_DIV_A: begin
            cmd.op   = OP_DIV_A;
            state_in = ST_WAIT_A;
         end
         ST_WAIT_A: begin
            if (stat.rem_done) begin
               cmd.op   = OP_TAKE_A;
               state_in = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            cmd.op   = OP_DIV_B;
            state_in = ST_WAIT_B;
         end
         ST_WAIT_B: begin
            if (stat.rem_done) begin
               cmd.op   = OP_TAKE_B;
               state_in = ST_STEP_ADD;
            end
         end
         ST_STEP_ADD: begin
            cmd.op   = OP_STEP_ADD;
            state_in = ST_STEP_MIN;
         end
         ST_STEP_MIN: begin
            cmd.op   = OP_STEP_MIN;
            state_in = ST_STEP_CHECK;
         end
         ST_STEP_CHECK: begin
            if (stat.step_fail) begin
               cmd.op   = OP_SET_RESULT;
               cmd.code = STATUS_NO_MEM;
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_ADVANCE;
               state_in = ST_RG_READ;
            end
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hdl/rrpa_datapath.sv @@
// Datapath: region and reservation stores, search arithmetic and result register.
module rrpa_datapath #(
   parameter int REGION_SLOTS  = 16,
   parameter int RESERVE_SLOTS = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rrpa_pkg::cmd_type           cmd,
   output rrpa_pkg::stat_type          stat,
   input  logic [1:0]                  req_tuser,
   input  logic [295:0]                req_tdata,
   input  logic                        csr_valid,
   input  logic [rrpa_pkg::ADDR_W-1:0] csr_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [71:0]                 rsp_tdata
);
   import rrpa_pkg::*;

   localparam int RG_AW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int RV_AW = $clog2(RESERVE_SLOTS);
   localparam int RV_CW = $clog2(RESERVE_SLOTS + 1);

   // captured item
   logic [1:0]        mode_ff;
   logic [3:0]        ri_ff;
   logic [ADDR_W-1:0] base_ff, len_ff, first_ff, last_ff;
   logic              usable_ff;
   logic [SIZE_W-1:0] size_ff, size_in;

   logic [ADDR_W-1:0] floor_ff;
   logic [RV_CW-1:0]  count_ff;
   logic [REGION_SLOTS-1:0] rg_valid_ff, rg_usable_ff;
   logic [RG_AW-1:0]  rg_idx_ff;
   logic [RV_CW-1:0]  rv_idx_ff;

   logic [ADDR_W-1:0] addr_ff, c_ff, off_ff, left_ff, top_ff, avail_ff, hi_ff, diff_ff;
   logic              ok_ff;
   logic [ADDR_W-1:0] stepa_ff;
   logic [ADDR_W:0]   stepb_ff, step_ff;

   logic [ADDR_W-1:0] res_addr_ff, rsp_addr_ff;
   status_type        res_status_ff, rsp_status_ff;
   logic              rsp_valid_ff;

   logic [2*ADDR_W-1:0] rg_wr_data, rg_rd_data, rv_wr_data, rv_rd_data;
   logic [ADDR_W-1:0]   rg_start, rg_len, rv_first, rv_last;
   logic                rg_wr_en, rv_wr_en, idx_ok;
   logic [SIZE_W-1:0]   req_size_raw, size_up;
   logic                rem_start, rem_done;
   logic [ADDR_W-1:0]   rem_dividend;
   logic [SIZE_W-1:0]   rem_value;

   assign rg_start = rg_rd_data[ADDR_W-1:0];
   assign rg_len   = rg_rd_data[2*ADDR_W-1:ADDR_W];
   assign rv_first = rv_rd_data[ADDR_W-1:0];
   assign rv_last  = rv_rd_data[2*ADDR_W-1:ADDR_W];

   assign idx_ok     = 32'(ri_ff) < REGION_SLOTS;
   assign rg_wr_en   = (cmd.op == OP_LOAD_REGION) && idx_ok;
   assign rg_wr_data = {len_ff, base_ff};
   assign rv_wr_en   = (cmd.op == OP_RESERVE) || (cmd.op == OP_COMMIT);
   assign rv_wr_data = (cmd.op == OP_COMMIT) ? {hi_ff, c_ff} : {last_ff, first_ff};

   rrpa_ram #(.WIDTH(2 * ADDR_W), .DEPTH(REGION_SLOTS), .AW(RG_AW)) u_region_ram (
      .clock   (clock),
      .wr_en   (rg_wr_en),
      .wr_addr (RG_AW'(ri_ff)),
      .wr_data (rg_wr_data),
      .rd_addr (rg_idx_ff),
      .rd_data (rg_rd_data)
   );

   rrpa_ram #(.WIDTH(2 * ADDR_W), .DEPTH(RESERVE_SLOTS), .AW(RV_AW)) u_reserve_ram (
      .clock   (clock),
      .wr_en   (rv_wr_en),
      .wr_addr (count_ff[RV_AW-1:0]),
      .wr_data (rv_wr_data),
      .rd_addr (rv_idx_ff[RV_AW-1:0]),
      .rd_data (rv_rd_data)
   );

   assign rem_start    = (cmd.op == OP_DIV_A) || (cmd.op == OP_DIV_B);
   assign rem_dividend = (cmd.op == OP_DIV_A) ? avail_ff : diff_ff;

   rrpa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (size_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // round the request up to whole pages, an empty request to one page
   assign req_size_raw = SIZE_W'(req_tdata[293:261]);
   assign size_up      = (req_size_raw + PAGE_MASK) & ~PAGE_MASK;
   assign size_in      = (req_size_raw == '0) ? PAGE_BYTES : size_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff      <= '0;
         count_ff      <= '0;
         rg_valid_ff   <= '0;
         rg_usable_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            floor_ff <= csr_data;
         end
         if (rg_wr_en) begin
            rg_valid_ff[RG_AW'(ri_ff)]  <= 1'b1;
            rg_usable_ff[RG_AW'(ri_ff)] <= usable_ff;
         end
         if (rv_wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            mode_ff   <= req_tuser;
            ri_ff     <= req_tdata[3:0];
            base_ff   <= req_tdata[67:4];
            len_ff    <= req_tdata[131:68];
            usable_ff <= req_tdata[132];
            first_ff  <= req_tdata[196:133];
            last_ff   <= req_tdata[260:197];
            size_ff   <= size_in;
         end
         OP_LOAD_REGION, OP_RESERVE: begin
            res_addr_ff   <= '0;
            res_status_ff <= STATUS_OK;
         end
         OP_SET_RESULT: begin
            res_addr_ff   <= '0;
            res_status_ff <= cmd.code;
         end
         OP_ALLOC_INIT: begin
            addr_ff   <= floor_ff;
            rg_idx_ff <= '0;
         end
         OP_RG_INC:   rg_idx_ff <= rg_idx_ff + 1'b1;
         OP_RG_MAX:   c_ff <= (addr_ff > rg_start) ? addr_ff : rg_start;
         OP_RG_OFF:   off_ff <= c_ff - rg_start;
         OP_RG_LEFT: begin
            ok_ff   <= off_ff <= rg_len;
            left_ff <= rg_len - off_ff;
            top_ff  <= (c_ff == '0) ? '1 : ('0 - c_ff);
         end
         OP_RG_AVAIL: avail_ff <= (left_ff < top_ff) ? left_ff : top_ff;
         OP_RV_FIRST: begin
            hi_ff     <= c_ff + (ADDR_W'(size_ff) - 1'b1);
            rv_idx_ff <= '0;
         end
         OP_RV_INC:   rv_idx_ff <= rv_idx_ff + 1'b1;
         OP_RV_LATCH: diff_ff <= rv_last - c_ff;
         OP_COMMIT: begin
            res_addr_ff   <= c_ff;
            res_status_ff <= STATUS_OK;
         end
         // whole steps that still fit the region, and that clear the reservation
         OP_TAKE_A:   stepa_ff <= avail_ff - ADDR_W'(rem_value);
         OP_TAKE_B:   stepb_ff <= {1'b0, diff_ff - ADDR_W'(rem_value)};
         OP_STEP_ADD: stepb_ff <= stepb_ff + (ADDR_W + 1)'(size_ff);
         OP_STEP_MIN: step_ff <= ({1'b0, stepa_ff} < stepb_ff) ? {1'b0, stepa_ff} : stepb_ff;
         OP_ADVANCE: begin
            addr_ff   <= c_ff + step_ff[ADDR_W-1:0];
            rg_idx_ff <= '0;
         end
         OP_EMIT: begin
            rsp_addr_ff   <= res_addr_ff;
            rsp_status_ff <= res_status_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.mode      = mode_ff;
      stat.full      = count_ff == RV_CW'(RESERVE_SLOTS);
      stat.usable    = rg_valid_ff[rg_idx_ff] && rg_usable_ff[rg_idx_ff];
      stat.rg_last   = rg_idx_ff == RG_AW'(REGION_SLOTS - 1);
      stat.fit       = ok_ff && (avail_ff >= ADDR_W'(size_ff));
      stat.rv_end    = rv_idx_ff == count_ff;
      stat.overlap   = !((rv_first > hi_ff) || (rv_last < c_ff));
      stat.rem_done  = rem_done;
      stat.step_fail = (c_ff != '0) && (step_ff >= {1'b0, top_ff});
      stat.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_addr_ff};

endmodule

@@ hdl/rrpa_checker.sv @@
// Port-level checks on the allocator, bound to the top level.
module rrpa_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata
);
   import rrpa_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[65:64] <= STATUS_FULL)
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65:64] != STATUS_OK |-> rsp_tdata[63:0] == 64'd0)
      else $error("failed result carries an address");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown straight after reset");

endmodule

bind reserved_range_page_allocator rrpa_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/reserved_range_page_allocator_tb.sv @@
// Self-checking testbench for the reserved range page allocator.
module reserved_range_page_allocator_tb;
   import rrpa_pkg::*;

   localparam int REGIONS   = 16;
   localparam int RESERVES  = 512;
   localparam int LIMIT     = 20000000;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic [1:0]  mode;
      logic [3:0]  idx;
      logic [63:0] base;
      logic [63:0] len;
      logic        usable;
      logic [63:0] rfirst;
      logic [63:0] rlast;
      logic [32:0] size;
   } alloc_item_type;

   typedef struct {
      logic [63:0] addr;
      status_type  status;
   } alloc_result_type;

   class alloc_scoreboard;
      logic [63:0]      floor_addr;
      logic [63:0]      rg_start [REGIONS];
      logic [63:0]      rg_len [REGIONS];
      bit               rg_valid [REGIONS];
      bit               rg_usable [REGIONS];
      logic [63:0]      rv_first [RESERVES];
      logic [63:0]      rv_last [RESERVES];
      int               rv_count;
      alloc_result_type expected_results[$];
      int               mismatches;

      function new();
         floor_addr = '0;
         rv_count   = 0;
         mismatches = 0;
         foreach (rg_valid[i]) begin
            rg_valid[i]  = 0;
            rg_usable[i] = 0;
         end
      endfunction

      // Bump search with skip past the overlapping reservation.
      function status_type place_block(logic [32:0] req, output logic [63:0] where);
         logic [63:0] size, addr, c, avail, off, left, top, hi;
         logic [63:0] kfail, kclear, k, step;
         int hit, ov;
         where = '0;
         c = '0;
         avail = '0;
         if (rv_count >= RESERVES) return STATUS_FULL;
         size = 64'(req);
         if (size == 0) size = 64'd4096;
         if (size[11:0] != 0) size = size + 64'd4096 - 64'(size[11:0]);
         addr = floor_addr;
         forever begin
            hit = -1;
            for (int r = 0; r < REGIONS; r++) begin
               if (rg_valid[r] && rg_usable[r]) begin
                  c = (addr > rg_start[r]) ? addr : rg_start[r];
                  off = c - rg_start[r];
                  if (off <= rg_len[r]) begin
                     left  = rg_len[r] - off;
                     top   = (c == 0) ? '1 : -c;
                     avail = (left < top) ? left : top;
                     if (avail >= size) begin
                        hit = r;
                        break;
                     end
                  end
               end
            end
            if (hit < 0) return STATUS_NO_MEM;
            hi = c + (size - 1);
            ov = -1;
            for (int i = 0; i < rv_count; i++) begin
               if (!(rv_first[i] > hi || rv_last[i] < c)) begin
                  ov = i;
                  break;
               end
            end
            if (ov < 0) begin
               rv_first[rv_count] = c;
               rv_last[rv_count]  = hi;
               rv_count++;
               where = c;
               return STATUS_OK;
            end
            kfail  = avail / size;
            kclear = (rv_last[ov] - c) / size + 1;
            k      = (kclear < kfail) ? kclear : kfail;
            step   = k * size;
            if (c != 0 && step >= -c) return STATUS_NO_MEM;
            addr = c + step;
         end
      endfunction

      function void note_request(alloc_item_type it);
         alloc_result_type res;
         res.addr   = '0;
         res.status = STATUS_OK;
         case (it.mode)
            MODE_REGION: begin
               rg_start[it.idx]  = it.base;
               rg_len[it.idx]    = it.len;
               rg_valid[it.idx]  = 1;
               rg_usable[it.idx] = it.usable;
            end
            MODE_RESERVE: begin
               if (rv_count >= RESERVES) res.status = STATUS_FULL;
               else begin
                  rv_first[rv_count] = it.rfirst;
                  rv_last[rv_count]  = it.rlast;
                  rv_count++;
               end
            end
            MODE_ALLOC: res.status = place_block(it.size, res.addr);
            default: ;
         endcase
         expected_results.push_back(res);
      endfunction

      function void check_response(logic [63:0] addr, logic [1:0] status);
         alloc_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected result addr=%h status=%0d", addr, status);
            return;
         end
         want = expected_results.pop_front();
         if (addr !== want.addr || status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("result mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                        want.addr, want.status, addr, status);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [295:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [63:0]  csr_data;

   alloc_scoreboard sb;
   bit  calm;
   bit  hold_rsp;
   int  rsp_wait;
   int  cycles;

   reserved_range_page_allocator #(
      .REGION_SLOTS  (REGIONS),
      .RESERVE_SLOTS (RESERVES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("reserved_range_page_allocator_tb: errors");
         $finish;
      end
   end

   // Receiver: random stall after each transfer, plus the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata[63:0], rsp_tdata[65:64]);
            rsp_wait = calm ? 0 : $urandom_range(0, 17);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= !hold_rsp && rsp_wait == 0;
      end
   end

   task automatic send_item(alloc_item_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= it.mode;
      req_tdata  <= {2'b0, it.size, it.rlast, it.rfirst, it.usable, it.len, it.base, it.idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_floor(logic [63:0] value);
      drain();
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.floor_addr = value;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic alloc_item_type blank_item(logic [1:0] mode);
      alloc_item_type it;
      it.mode   = mode;
      it.idx    = '0;
      it.base   = '0;
      it.len    = '0;
      it.usable = 0;
      it.rfirst = '0;
      it.rlast  = '0;
      it.size   = '0;
      return it;
   endfunction

   task automatic load_region(int idx, logic [63:0] base, logic [63:0] len, bit usable);
      alloc_item_type it;
      it = blank_item(MODE_REGION);
      it.idx = 4'(idx);
      it.base = base;
      it.len = len;
      it.usable = usable;
      send_item(it);
   endtask

   task automatic reserve_range(logic [63:0] first, logic [63:0] last);
      alloc_item_type it;
      it = blank_item(MODE_RESERVE);
      it.rfirst = first;
      it.rlast = last;
      send_item(it);
   endtask

   task automatic alloc_bytes(logic [32:0] size);
      alloc_item_type it;
      it = blank_item(MODE_ALLOC);
      it.size = size;
      send_item(it);
   endtask

   // Fully random inverted range: only catches candidates spanning it.
   task automatic reserve_inverted_random();
      logic [63:0] a, b;
      a = rand64();
      b = rand64();
      if (a < b) reserve_range(b, a);
      else reserve_range(a, b);
   endtask

   task automatic random_item(logic [63:0] win);
      alloc_item_type it;
      int pick;
      logic [63:0] first;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if ($urandom_range(0, 9) == 0)
            load_region($urandom_range(0, 15), rand64(), rand64(), $urandom_range(0, 1));
         else
            load_region($urandom_range(0, 15),
                        win + (64'($urandom_range(0, 63)) << 12) + 64'($urandom_range(0, 1)),
                        (64'($urandom_range(1, 512)) << 12) +
                           (($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : 0),
                        $urandom_range(0, 4) != 0);
      end else if (pick < 45) begin
         if ($urandom_range(0, 7) == 0) reserve_inverted_random();
         else begin
            first = win + (64'($urandom_range(0, 1023)) << 12) + 64'($urandom_range(0, 4095));
            if ($urandom_range(0, 9) == 0)
               reserve_range(first + 64'h2000, first);
            else
               reserve_range(first, first + (64'($urandom_range(0, 8)) << 12) + 64'hFFF);
         end
      end else if (pick < 95) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) alloc_bytes(33'($urandom_range(1, 32768)));
         else if (pick < 95) alloc_bytes(33'($urandom_range(0, 4)) << 12);
         else alloc_bytes({1'($urandom), $urandom});
      end else begin
         it.mode   = MODE_NONE;
         it.idx    = 4'($urandom);
         it.base   = rand64();
         it.len    = rand64();
         it.usable = 1'($urandom);
         it.rfirst = rand64();
         it.rlast  = rand64();
         it.size   = {1'($urandom), $urandom};
         send_item(it);
      end
   endtask

   initial begin
      logic [63:0] win;
      int need;
      sb = new();
      cycles = 0;
      calm = 0;
      hold_rsp = 0;
      reset = 1;
      req_tvalid = 0;
      req_tuser = '0;
      req_tdata = '0;
      csr_valid = 0;
      csr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with the floor at its reset value of zero.
      set_floor(64'h0);
      load_region(0, 64'h10000, 64'h40000, 1);
      load_region(1, 64'h0, 64'h100000, 0);
      load_region(15, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1);
      alloc_bytes(33'd0);
      alloc_bytes(33'd1);
      alloc_bytes(33'd4097);
      reserve_range(64'h20000, 64'h20FFF);
      alloc_bytes(33'h3000);
      reserve_range(64'h30000, 64'h2F000);
      alloc_bytes(33'h1_0000_0000);
      alloc_bytes(33'h1_FFFF_FFFF);
      reserve_range(64'h0, 64'h0);
      reserve_range('1, '1);
      random_item(64'h0);
      alloc_bytes(33'h40000);
      alloc_bytes(33'h1000);
      set_floor('1);
      alloc_bytes(33'h1000);
      alloc_bytes(33'd0);
      set_floor(64'h10800);
      alloc_bytes(33'h800);
      alloc_bytes(33'h2000);

      for (int p = 1; p <= 12; p++) begin
         win = (64'(p) << 40) + (64'($urandom_range(0, 255)) << 20);
         set_floor(($urandom_range(0, 7) == 0) ? win + 64'($urandom_range(1, 4095)) : win);
         calm = (p % 3 == 0);
         if (p == 1) begin
            // Hold the result channel so the block backs up onto its input.
            hold_rsp <= 1;
            fork
               begin
                  repeat (400) @(posedge clock);
                  hold_rsp <= 0;
               end
            join_none
         end
         load_region($urandom_range(0, 15), win, 64'h10_0000, 1);
         load_region($urandom_range(0, 15), win + 64'h20_0000, 64'h8_0000, 1);
         for (int n = 0; n < 38; n++) random_item(win);
      end

      // Fill the reservation table and go past full.
      calm = 0;
      set_floor(64'h0);
      need = RESERVES - sb.rv_count + 3;
      for (int n = 0; n < need; n++) reserve_inverted_random();
      alloc_bytes(33'h1000);
      alloc_bytes(33'd0);
      alloc_bytes({1'($urandom), $urandom});

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0)
         $display("reserved_range_page_allocator_tb: clean");
      else
         $display("reserved_range_page_allocator_tb: errors");
      $finish;
   end

endmodule
